FILE: src/ptem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptem_pkg
// Shared types and constants for the periodic threshold event monitor.
// ----------------------------------------------------------------------------
package ptem_pkg;

	localparam int NUM_SLOTS = 4;
	localparam int NUM_PINS  = 11;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int PIN_W     = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
	localparam int CMDQ_DEPTH = 2;

	localparam logic [31:0] DEFAULT_INTERVAL_RST = 32'd100000;
	localparam logic [7:0]  TYPE_PIN  = 8'h01;
	localparam logic [7:0]  TYPE_TEMP = 8'h02;

	localparam logic [7:0] OP_GT = 8'd0;
	localparam logic [7:0] OP_LT = 8'd1;
	localparam logic [7:0] OP_EQ = 8'd2;
	localparam logic [7:0] OP_NE = 8'd3;

	localparam logic [0:0] REG_DEFAULT_INTERVAL = 1'b0;

	typedef enum logic [2:0] {
		FN_TICK   = 3'd0,
		FN_PWRITE = 3'd1,
		FN_PREAD  = 3'd2,
		FN_REG    = 3'd3,
		FN_STOP   = 3'd4,
		FN_STATUS = 3'd5,
		FN_RSV6   = 3'd6,
		FN_RSV7   = 3'd7
	} func_t;

	typedef enum logic [2:0] {
		K_EVENT   = 3'd0,
		K_REG     = 3'd1,
		K_NOSLOT  = 3'd2,
		K_WRITTEN = 3'd3,
		K_PINERR  = 3'd4,
		K_STOPPED = 3'd5,
		K_PINVAL  = 3'd6,
		K_STATUS  = 3'd7
	} kind_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  temperature;
		logic [7:0]  pin;
		logic [31:0] pin_value;
		logic [7:0]  mon_type;
		logic [7:0]  cond_op;
		logic [31:0] threshold;
		logic [31:0] interval;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  slot;
		logic [7:0]  source_type;
		logic [31:0] sample;
		logic [7:0]  pin_index;
		logic [31:0] trigger_total;
		logic        fired_flag;
		logic        active_flag;
		logic        last;
	} rsp_t;

	// classified command passed from front to back
	typedef struct packed {
		func_t       fn;
		logic        pin_ok;
		logic        slot_ok;
		req_t        req;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_SCAN = 2'd1,
		BK_ONE  = 2'd2
	} bk_state_t;

	function automatic logic cmp_hit(logic [7:0] op, logic [31:0] v, logic [31:0] t);
		logic r;
		r = 1'b0;
		case (op)
			OP_GT: r = v > t;
			OP_LT: r = v < t;
			OP_EQ: r = v == t;
			OP_NE: r = v != t;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: src/ptem_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptem_req_if / ptem_rsp_if
// Valid/ready channels carrying requests and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface ptem_req_if;
	logic             valid;
	logic             ready;
	ptem_pkg::req_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ptem_rsp_if;
	logic             valid;
	logic             ready;
	ptem_pkg::rsp_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/ptem_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptem_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module ptem_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	ptem_req_if.sink           req,
	output ptem_pkg::cmd_t     cmd,
	output logic               cmd_valid,
	input  wire logic          cmd_pop
);
	import ptem_pkg::*;

	cmd_t       q_mem_q [CMDQ_DEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t       c;
	logic       push;

	always_comb begin
		c.fn      = func_t'(req.data.func);
		c.pin_ok  = {24'd0, req.data.pin} < 32'(NUM_PINS);
		c.slot_ok = {24'd0, req.data.pin} < 32'(NUM_SLOTS);
		c.req     = req.data;
	end

	assign req.ready = cnt_q != 2'(CMDQ_DEPTH);
	assign push      = req.valid && req.ready;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (cmd_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end
endmodule
`default_nettype wire

FILE: src/ptem_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptem_back
// Executes commands: pin file, slot state and the per-slot tick scan.
// ----------------------------------------------------------------------------
`default_nettype none
module ptem_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  ptem_pkg::cmd_t     cmd,
	input  wire logic          cmd_valid,
	output logic               cmd_pop,
	input  wire logic [31:0]   default_interval,
	ptem_rsp_if.source         rsp
);
	import ptem_pkg::*;

	logic [31:0] pins_q [NUM_PINS];
	logic        act_q   [NUM_SLOTS];
	logic        fired_q [NUM_SLOTS];
	logic [31:0] trig_q  [NUM_SLOTS];
	logic [7:0]  typ_q   [NUM_SLOTS];
	logic [7:0]  spin_q  [NUM_SLOTS];
	logic [7:0]  op_q    [NUM_SLOTS];
	logic [31:0] thr_q   [NUM_SLOTS];
	logic [31:0] ivl_q   [NUM_SLOTS];
	logic [31:0] cnt_q   [NUM_SLOTS];
	logic [31:0] smp_q   [NUM_SLOTS];

	bk_state_t   st_q, st_d;
	logic [SLOT_W:0] idx_q;
	logic [SLOT_W-1:0] s;
	logic        have_q;   // an event is held back until we know if it is last
	rsp_t        hold_q;
	logic        ovalid_q;
	rsp_t        out_q;
	logic        out_free;

	logic [31:0] dec, v;
	logic        hit, fire;
	logic [SLOT_W-1:0] free_s;
	logic        free_ok;
	logic [SLOT_W-1:0] ss;
	rsp_t        one;
	rsp_t        fin;
	logic        emit_one;
	logic        scan_step, scan_end;

	assign rsp.valid = ovalid_q;
	assign rsp.data  = out_q;
	assign out_free  = !ovalid_q || rsp.ready;
	assign s  = idx_q[SLOT_W-1:0];
	assign ss = cmd.req.pin[SLOT_W-1:0];

	// tick evaluation of slot s
	always_comb begin
		dec = cnt_q[s] - 32'd1;
		v = 32'd0;
		if (typ_q[s] == TYPE_PIN) begin
			if ({24'd0, spin_q[s]} < 32'(NUM_PINS)) v = pins_q[spin_q[s][PIN_W-1:0]];
		end else if (typ_q[s] == TYPE_TEMP) begin
			v = {24'd0, cmd.req.temperature};
		end
		hit  = cmp_hit(op_q[s], v, thr_q[s]);
		fire = act_q[s] && dec == 32'd0 && hit && !fired_q[s];
	end

	always_comb begin
		free_ok = 1'b0;
		free_s  = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!act_q[i]) begin
				free_ok = 1'b1;
				free_s  = SLOT_W'(i);
			end
		end
	end

	// final event of a tick
	always_comb begin
		fin = hold_q;
		fin.last = 1'b1;
	end

	// single result for non-tick commands
	always_comb begin
		one = '0;
		one.last = 1'b1;
		emit_one = 1'b1;
		case (cmd.fn)
			FN_PWRITE: begin
				one.kind = cmd.pin_ok ? K_WRITTEN : K_PINERR;
				one.sample = cmd.pin_ok ? cmd.req.pin_value : 32'd0;
				one.pin_index = cmd.req.pin;
			end
			FN_PREAD: begin
				one.kind = K_PINVAL;
				one.sample = cmd.pin_ok ? pins_q[cmd.req.pin[PIN_W-1:0]] : 32'd0;
				one.pin_index = cmd.req.pin;
			end
			FN_REG: begin
				if (free_ok) begin
					one.kind = K_REG;
					one.slot = 2'(free_s);
					one.source_type = cmd.req.mon_type;
					one.pin_index = cmd.req.pin;
					one.active_flag = 1'b1;
				end else begin
					one.kind = K_NOSLOT;
				end
			end
			FN_STOP: one.kind = K_STOPPED;
			FN_STATUS: begin
				if (cmd.slot_ok) begin
					one.kind = K_STATUS;
					one.slot = 2'(ss);
					one.source_type = typ_q[ss];
					one.sample = smp_q[ss];
					one.pin_index = spin_q[ss];
					one.trigger_total = trig_q[ss];
					one.fired_flag = fired_q[ss];
					one.active_flag = act_q[ss];
				end else begin
					one.kind = K_PINERR;
					one.pin_index = cmd.req.pin;
				end
			end
			default: emit_one = 1'b0;
		endcase
	end

	// a scan step needs room for the held event if this slot fires
	assign scan_step = (st_q == BK_SCAN) && (!(fire && have_q) || out_free);
	assign scan_end  = scan_step && idx_q == (SLOT_W+1)'(NUM_SLOTS - 1);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (cmd_valid) st_d = (cmd.fn == FN_TICK) ? BK_SCAN : BK_ONE;
			BK_SCAN: if (scan_end) st_d = have_q || fire ? BK_ONE : BK_IDLE;
			BK_ONE:  if (out_free) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = 1'b0;
		unique case (st_q)
			BK_SCAN: cmd_pop = scan_end && !(have_q || fire);
			BK_ONE:  cmd_pop = out_free && (cmd.fn != FN_TICK || have_q);
			default: cmd_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (scan_step && act_q[s]) begin
			if (dec == 32'd0) begin
				cnt_q[s] <= ivl_q[s];
				smp_q[s] <= v;
			end else begin
				cnt_q[s] <= dec;
			end
		end
		if (st_q == BK_ONE && out_free && cmd.fn == FN_REG && free_ok) begin
			typ_q[free_s]  <= cmd.req.mon_type;
			spin_q[free_s] <= cmd.req.pin;
			op_q[free_s]   <= cmd.req.cond_op;
			thr_q[free_s]  <= cmd.req.threshold;
			ivl_q[free_s]  <= cmd.req.interval != 0 ? cmd.req.interval : default_interval;
			cnt_q[free_s]  <= cmd.req.interval != 0 ? cmd.req.interval : default_interval;
			smp_q[free_s]  <= 32'd0;
		end
		if (scan_step && fire) begin
			hold_q.kind <= K_EVENT;
			hold_q.slot <= 2'(s);
			hold_q.source_type <= typ_q[s];
			hold_q.sample <= v;
			hold_q.pin_index <= spin_q[s];
			hold_q.trigger_total <= trig_q[s] + 32'd1;
			hold_q.fired_flag <= 1'b1;
			hold_q.active_flag <= 1'b1;
			hold_q.last <= 1'b0;
		end
		if (st_q == BK_SCAN && scan_step && fire && have_q) out_q <= hold_q;
		else if (st_q == BK_ONE && out_free) out_q <= (cmd.fn == FN_TICK) ? fin : one;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			idx_q <= '0;
			have_q <= 1'b0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < NUM_PINS; i++) pins_q[i] <= 32'd0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				act_q[i] <= 1'b0;
				fired_q[i] <= 1'b0;
				trig_q[i] <= 32'd0;
			end
		end else begin
			st_q <= st_d;
			if (st_q == BK_IDLE) idx_q <= '0;
			else if (scan_step) idx_q <= idx_q + 1'b1;
			if (scan_step && act_q[s] && dec == 32'd0) begin
				if (fire) begin
					trig_q[s] <= trig_q[s] + 32'd1;
					fired_q[s] <= 1'b1;
				end else if (!hit) begin
					fired_q[s] <= 1'b0;
				end
			end
			if (scan_step && fire) have_q <= 1'b1;
			if (scan_step && fire && have_q) ovalid_q <= 1'b1;
			else if (st_q == BK_ONE && out_free)
				ovalid_q <= cmd.fn == FN_TICK ? 1'b1 : emit_one;
			else if (rsp.ready) ovalid_q <= 1'b0;
			if (st_q == BK_ONE && out_free) begin
				have_q <= 1'b0;
				if (cmd.fn == FN_PWRITE && cmd.pin_ok)
					pins_q[cmd.req.pin[PIN_W-1:0]] <= cmd.req.pin_value;
				if (cmd.fn == FN_REG && free_ok) begin
					act_q[free_s] <= 1'b1;
					fired_q[free_s] <= 1'b0;
					trig_q[free_s] <= 32'd0;
				end
				if (cmd.fn == FN_STOP) begin
					for (int i = 0; i < NUM_SLOTS; i++) begin
						act_q[i] <= 1'b0;
						fired_q[i] <= 1'b0;
						trig_q[i] <= 32'd0;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/periodic_threshold_event_monitor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_threshold_event_monitor_unit
// Pin register file with four periodic threshold monitor slots.
// ----------------------------------------------------------------------------
// Usage:
//   req  : valid/ready request channel (func selects the command).
//   rsp  : valid/ready result channel; last marks a request's final result.
//   APB  : one register, default_interval at address 0, pready always high.
// Requests enter a two-entry queue; the back end runs one at a time.
// The back end takes each command from the queue in its idle state. A tick
// then walks the four slots, one slot per cycle unless a held event waits
// for a stalled output, and then delivers its final event; other commands
// go straight on to delivering their result.
// A tick that fires nothing returns no result; func 6 and 7 are dropped.
// When the receiver stalls, the back end holds its output register and
// pauses; the queue keeps taking requests until full.
// Reset clears the pin file, slot activity, fired marks and trigger counts
// and sets default_interval to 100000.
// ----------------------------------------------------------------------------
`default_nettype none
module periodic_threshold_event_monitor_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ptem_req_if.sink         req,
	ptem_rsp_if.source       rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [0:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import ptem_pkg::*;

	logic [31:0] dflt_q;
	cmd_t        cmd;
	logic        cmd_valid, cmd_pop;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_DEFAULT_INTERVAL) ? dflt_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dflt_q <= DEFAULT_INTERVAL_RST;
		else if (psel && penable && pwrite && paddr == REG_DEFAULT_INTERVAL) dflt_q <= pwdata;
	end

	ptem_front u_front (
		.clk, .arst_n, .req, .cmd, .cmd_valid, .cmd_pop
	);

	ptem_back u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_pop,
		.default_interval(dflt_q), .rsp
	);
endmodule
`default_nettype wire

FILE: src/ptem_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptem_checker
// Port-level checks of the monitor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module ptem_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input ptem_pkg::rsp_t   rsp_data,
	input wire logic        pready
);
	import ptem_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");
	a_evt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.kind == K_EVENT |-> rsp_data.fired_flag && rsp_data.active_flag)
		else $error("event without fired/active");
	a_nonlast: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.last |-> rsp_data.kind == K_EVENT)
		else $error("non-final result that is not an event");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind periodic_threshold_event_monitor_unit ptem_checker u_chk (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_data(rsp.data), .pready(pready)
);
`default_nettype wire
